// ===== hw/rtl/rlf_pkg.sv =====
// Shared types and constants of the redundant link failover block.
// No dependencies; every other file of the block refers to this package.
package rlf_pkg;

	localparam int KIND_W = 3;
	localparam int ID_W   = 3;
	localparam int TMO_W  = 16;
	localparam int CIDX_W = 2;
	localparam int CNT_W  = 4;
	localparam int MASK_W = 8;

	// Item kinds.
	localparam logic [KIND_W-1:0] K_MSG   = 3'd0;
	localparam logic [KIND_W-1:0] K_TICK  = 3'd1;
	localparam logic [KIND_W-1:0] K_DISC  = 3'd2;
	localparam logic [KIND_W-1:0] K_SEL   = 3'd3;
	localparam logic [KIND_W-1:0] K_CLOSE = 3'd4;

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] R_LOST_CHECK = 2'd0;
	localparam logic [CIDX_W-1:0] R_TIMEOUT    = 2'd1;
	localparam logic [CIDX_W-1:0] R_AUTO_DISC  = 2'd2;

	localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd3500;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_APPLY,
		ST_SCAN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic apply;
		logic scan;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic scan_more;
		logic scan_last;
		logic out_free;
	} status_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   link_id;
		logic              is_radio_status;
		logic              link_usb_direct;
		logic              link_high_latency;
	} item_t;

	typedef struct packed {
		logic              primary_valid;
		logic [ID_W-1:0]   primary_link;
		logic              primary_changed;
		logic [MASK_W-1:0] lost_mask;
		logic              total_lost;
		logic              hl_stop;
		logic [ID_W-1:0]   hl_stop_link;
		logic              hl_start;
		logic              all_removed;
		logic [CNT_W-1:0]  link_count;
	} result_t;

endpackage

// ===== hw/rtl/rlf_item_if.sv =====
// Input item channel of the failover block.
// Depends on rlf_pkg for field widths.
interface rlf_item_if;
	logic                          valid;
	logic                          ready;
	logic [rlf_pkg::KIND_W-1:0]    kind;
	logic [rlf_pkg::ID_W-1:0]      link_id;
	logic                          is_radio_status;
	logic                          link_usb_direct;
	logic                          link_high_latency;

	modport source (output valid, kind, link_id, is_radio_status, link_usb_direct,
		link_high_latency, input ready);
	modport sink (input valid, kind, link_id, is_radio_status, link_usb_direct,
		link_high_latency, output ready);
endinterface

// ===== hw/rtl/rlf_result_if.sv =====
// Result channel of the failover block.
// Depends on rlf_pkg for field widths.
interface rlf_result_if;
	logic                          valid;
	logic                          ready;
	logic                          primary_valid;
	logic [rlf_pkg::ID_W-1:0]      primary_link;
	logic                          primary_changed;
	logic [rlf_pkg::MASK_W-1:0]    lost_mask;
	logic                          total_lost;
	logic                          hl_stop;
	logic [rlf_pkg::ID_W-1:0]      hl_stop_link;
	logic                          hl_start;
	logic                          all_removed;
	logic [rlf_pkg::CNT_W-1:0]     link_count;

	modport source (output valid, primary_valid, primary_link, primary_changed,
		lost_mask, total_lost, hl_stop, hl_stop_link, hl_start, all_removed,
		link_count, input ready);
	modport sink (input valid, primary_valid, primary_link, primary_changed,
		lost_mask, total_lost, hl_stop, hl_stop_link, hl_start, all_removed,
		link_count, output ready);
endinterface

// ===== hw/rtl/rlf_cfg_if.sv =====
// Configuration write channel of the failover block.
// Depends on rlf_pkg for the index and data widths.
interface rlf_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [rlf_pkg::CIDX_W-1:0]    index;
	logic [rlf_pkg::TMO_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/rlf_ctrl.sv =====
// Sequencer of the failover block: accept, apply, scan of the order list, finish.
// Depends on rlf_pkg for the state, command and status types.
module rlf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rlf_pkg::status_t  sts,
	output rlf_pkg::cmd_t     cmd
);

	rlf_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rlf_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rlf_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = rlf_pkg::ST_APPLY;
			end
			rlf_pkg::ST_APPLY: state_nxt = rlf_pkg::ST_SCAN;
			rlf_pkg::ST_SCAN: begin
				if (!sts.scan_more || sts.scan_last) state_nxt = rlf_pkg::ST_FIN;
			end
			rlf_pkg::ST_FIN: begin
				if (sts.out_free) state_nxt = rlf_pkg::ST_IDLE;
			end
			default: state_nxt = rlf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd        = '0;
		unique case (state_q)
			rlf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			rlf_pkg::ST_APPLY: cmd.apply = 1'b1;
			rlf_pkg::ST_SCAN:  cmd.scan = sts.scan_more;
			rlf_pkg::ST_FIN:   cmd.finish = sts.out_free;
			default: ;
		endcase
	end

endmodule

// ===== hw/rtl/rlf_dp.sv =====
// Datapath of the failover block: link table, order list, candidate scan,
// primary reselection and the result register. Depends on rlf_pkg.
module rlf_dp #(
	parameter int LINKS    = 8,
	parameter int AGE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rlf_pkg::cmd_t                cmd,
	output rlf_pkg::status_t             sts,
	input  rlf_pkg::item_t               item,
	input  logic                         cfg_valid,
	input  logic [rlf_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [rlf_pkg::TMO_W-1:0]    cfg_data,
	output rlf_pkg::result_t             res,
	output logic                         out_valid,
	input  logic                         out_ready
);

	localparam int SW = (LINKS > 1) ? $clog2(LINKS) : 1;
	localparam int CW = $clog2(LINKS + 1);
	localparam int MW = (LINKS < 8) ? LINKS : 8;
	localparam int CMP_W = 33;

	logic                 chk_en_q, auto_dc_q;
	logic [rlf_pkg::TMO_W-1:0] timeout_q;

	logic [LINKS-1:0]     used_q, usb_q, hl_q, lost_q;
	logic [AGE_BITS-1:0]  age_q [LINKS];
	logic [SW-1:0]        order_q [LINKS];
	logic [CW-1:0]        count_q;
	logic                 prim_v_q, all_lost_q, closed_q;
	logic [SW-1:0]        prim_q;

	rlf_pkg::item_t       item_q;
	logic                 was_v_q;
	logic [SW-1:0]        was_q;
	logic                 resel_q, regain_q, tchk_q, disc_q, rm_q;

	logic [CW-1:0]        pos_q;
	logic                 cu_v_q, cn_v_q, ch_v_q;
	logic [SW-1:0]        cu_q, cn_q, ch_q;

	rlf_pkg::result_t     res_q;
	logic                 out_valid_q;

	// Decoded item.
	logic [SW-1:0]        s;
	logic                 id_ok;
	logic [LINKS-1:0]     m, ge;
	logic [SW-1:0]        t;

	assign s     = SW'(item_q.link_id);
	assign id_ok = 5'(item_q.link_id) < 5'(LINKS);
	assign t     = order_q[pos_q[SW-1:0]];

	// Position of the removed slot in the order list; entries from there on move up.
	always_comb begin
		logic acc;
		acc = 1'b0;
		for (int j = 0; j < LINKS; j++) begin
			m[j]  = (CW'(j) < count_q) && (order_q[j] == s);
			acc   = acc | m[j];
			ge[j] = acc;
		end
	end

	// Reselection and end-of-item bookkeeping.
	logic          keep, found, do_sel, f_stop, f_start, f_close;
	logic          f_prim_v, f_all_lost, f_rm;
	logic [SW-1:0] pick, f_prim;

	always_comb begin
		keep = prim_v_q && !lost_q[prim_q] && !hl_q[prim_q];
		found = 1'b1;
		pick  = cu_q;
		priority if (cu_v_q) pick = cu_q;
		else if (cn_v_q) pick = cn_q;
		else if (prim_v_q && hl_q[prim_q]) pick = prim_q;
		else if (ch_v_q) pick = ch_q;
		else begin
			found = 1'b0;
			pick  = '0;
		end
		do_sel = resel_q && !keep && !(prim_v_q && !found)
			&& !(found == prim_v_q && (!found || pick == prim_q));
		f_stop   = do_sel && prim_v_q && hl_q[prim_q];
		f_start  = do_sel && found && hl_q[pick];
		f_prim_v = do_sel ? found : prim_v_q;
		f_prim   = do_sel ? pick : prim_q;

		f_all_lost = all_lost_q;
		f_close    = 1'b0;
		f_rm       = rm_q;
		if (regain_q && all_lost_q && !(|lost_q)) f_all_lost = 1'b0;
		if (tchk_q && !all_lost_q && (&(lost_q | ~used_q))) begin
			if (auto_dc_q) f_close = 1'b1;
			else f_all_lost = 1'b1;
		end
		if (f_close) begin
			f_rm     = 1'b1;
			f_prim_v = 1'b0;
			f_prim   = '0;
		end
		if (disc_q && count_q == '0 && !closed_q) f_rm = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_en_q    <= 1'b1;
			timeout_q   <= rlf_pkg::TIMEOUT_RST;
			auto_dc_q   <= 1'b0;
			used_q      <= '0;
			usb_q       <= '0;
			hl_q        <= '0;
			lost_q      <= '0;
			for (int i = 0; i < LINKS; i++) age_q[i] <= '0;
			count_q     <= '0;
			prim_v_q    <= 1'b0;
			prim_q      <= '0;
			all_lost_q  <= 1'b0;
			closed_q    <= 1'b0;
			resel_q     <= 1'b0;
			regain_q    <= 1'b0;
			tchk_q      <= 1'b0;
			disc_q      <= 1'b0;
			rm_q        <= 1'b0;
			pos_q       <= '0;
			cu_v_q      <= 1'b0;
			cn_v_q      <= 1'b0;
			ch_v_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					rlf_pkg::R_LOST_CHECK: chk_en_q <= cfg_data[0];
					rlf_pkg::R_TIMEOUT:    timeout_q <= cfg_data;
					rlf_pkg::R_AUTO_DISC:  auto_dc_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				resel_q  <= 1'b0;
				regain_q <= 1'b0;
				tchk_q   <= 1'b0;
				disc_q   <= 1'b0;
				rm_q     <= 1'b0;
			end
			if (cmd.apply) begin
				pos_q  <= '0;
				cu_v_q <= 1'b0;
				cn_v_q <= 1'b0;
				ch_v_q <= 1'b0;
				unique case (item_q.kind)
					rlf_pkg::K_MSG: begin
						if (!item_q.is_radio_status && id_ok) begin
							if (!used_q[s]) begin
								if (count_q < CW'(LINKS)) begin
									used_q[s] <= 1'b1;
									usb_q[s]  <= item_q.link_usb_direct;
									hl_q[s]   <= item_q.link_high_latency;
									lost_q[s] <= 1'b0;
									age_q[s]  <= '0;
									count_q   <= count_q + 1'b1;
									resel_q   <= 1'b1;
								end
							end else begin
								age_q[s] <= '0;
								if (lost_q[s]) begin
									lost_q[s] <= 1'b0;
									resel_q   <= 1'b1;
									regain_q  <= 1'b1;
								end
							end
						end
					end
					rlf_pkg::K_TICK: begin
						if (count_q != '0) begin
							for (int i = 0; i < LINKS; i++) begin
								if (used_q[i]) begin
									if (age_q[i] != '1) age_q[i] <= age_q[i] + 1'b1;
									// The timeout test sees the age after this tick.
									if (chk_en_q && !lost_q[i] && !hl_q[i] &&
										CMP_W'(age_q[i]) + CMP_W'(age_q[i] != '1) >
										CMP_W'(timeout_q))
										lost_q[i] <= 1'b1;
								end
							end
							resel_q <= chk_en_q;
							tchk_q  <= chk_en_q;
						end
					end
					rlf_pkg::K_DISC: begin
						if (id_ok && used_q[s]) begin
							if (prim_v_q && prim_q == s) begin
								prim_v_q <= 1'b0;
								prim_q   <= '0;
							end
							used_q[s] <= 1'b0;
							usb_q[s]  <= 1'b0;
							hl_q[s]   <= 1'b0;
							lost_q[s] <= 1'b0;
							age_q[s]  <= '0;
							count_q   <= count_q - 1'b1;
							resel_q   <= 1'b1;
							disc_q    <= 1'b1;
						end
					end
					rlf_pkg::K_SEL: begin
						if (id_ok && used_q[s]) begin
							prim_v_q <= 1'b1;
							prim_q   <= s;
						end
					end
					rlf_pkg::K_CLOSE: begin
						used_q   <= '0;
						usb_q    <= '0;
						hl_q     <= '0;
						lost_q   <= '0;
						for (int i = 0; i < LINKS; i++) age_q[i] <= '0;
						count_q  <= '0;
						prim_v_q <= 1'b0;
						prim_q   <= '0;
						closed_q <= 1'b1;
						rm_q     <= 1'b1;
					end
					default: ;
				endcase
			end
			if (cmd.scan) begin
				pos_q <= pos_q + 1'b1;
				if (!cu_v_q && !lost_q[t] && usb_q[t]) begin
					cu_v_q <= 1'b1;
					cu_q   <= t;
				end
				if (!cn_v_q && !lost_q[t] && !hl_q[t]) begin
					cn_v_q <= 1'b1;
					cn_q   <= t;
				end
				if (!ch_v_q && !lost_q[t] && hl_q[t]) begin
					ch_v_q <= 1'b1;
					ch_q   <= t;
				end
			end
			if (cmd.finish) begin
				prim_v_q    <= f_prim_v;
				prim_q      <= f_prim;
				all_lost_q  <= f_all_lost;
				if (f_close) begin
					used_q   <= '0;
					usb_q    <= '0;
					hl_q     <= '0;
					lost_q   <= '0;
					for (int i = 0; i < LINKS; i++) age_q[i] <= '0;
					count_q  <= '0;
					closed_q <= 1'b1;
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item capture, order list and result payload carry no reset.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q  <= item;
			was_v_q <= prim_v_q;
			was_q   <= prim_q;
		end
		if (cmd.apply) begin
			if (item_q.kind == rlf_pkg::K_MSG && !item_q.is_radio_status && id_ok &&
				!used_q[s] && count_q < CW'(LINKS))
				order_q[count_q[SW-1:0]] <= s;
			if (item_q.kind == rlf_pkg::K_DISC && id_ok && used_q[s]) begin
				for (int j = 0; j < LINKS - 1; j++)
					if (ge[j]) order_q[j] <= order_q[j+1];
			end
		end
		if (cmd.finish) begin
			res_q.primary_valid   <= f_prim_v;
			res_q.primary_link    <= f_prim_v ? rlf_pkg::ID_W'(f_prim) : '0;
			res_q.primary_changed <= (f_prim_v != was_v_q) || (f_prim_v && f_prim != was_q);
			res_q.lost_mask       <= f_close ? '0
				: rlf_pkg::MASK_W'(used_q[MW-1:0] & lost_q[MW-1:0]);
			res_q.total_lost      <= f_all_lost;
			res_q.hl_stop         <= f_stop;
			res_q.hl_stop_link    <= f_stop ? rlf_pkg::ID_W'(prim_q) : '0;
			res_q.hl_start        <= f_start;
			res_q.all_removed     <= f_rm;
			res_q.link_count      <= f_close ? '0 : rlf_pkg::CNT_W'(count_q);
		end
	end

	assign sts.scan_more = resel_q && (pos_q < count_q);
	assign sts.scan_last = (CW'(pos_q + 1'b1) >= count_q);
	assign sts.out_free  = !out_valid_q || out_ready;
	assign res           = res_q;
	assign out_valid     = out_valid_q;

endmodule

// ===== hw/rtl/redundant_link_failover.sv =====
// Top level of the redundant link failover block.
// Depends on rlf_pkg, the three channel interfaces, rlf_ctrl and rlf_dp.
//
// Usage: events arrive as beats on the item channel (message, tick,
// disconnect, select primary, close all); every item yields exactly one
// beat on the result channel with the primary link, loss state and
// high-latency start/stop requests. Configuration beats on cfg are always
// taken and land the next cycle; write them only while the block is idle.
// Sequence: an item passes from its beat through the apply, scan and finish
// states; the scan state walks the insertion-order list one entry per
// cycle only when a reselection runs, and otherwise moves straight on to finish.
// The block takes one item at a time, so a new item is accepted only
// once its predecessor has finished.
// The result sits in an output register: if the receiver stalls, the next
// item is still accepted and worked, and waits before its result is written.
// Reset empties the table, clears the primary and the loss flags, and loads
// the register defaults (checking on, timeout 3500 ticks, auto-disconnect off).
module redundant_link_failover #(
	parameter int LINKS    = 8,
	parameter int AGE_BITS = 16
) (
	input logic         clk,
	input logic         arst_n,
	rlf_item_if.sink    item,
	rlf_result_if.source result,
	rlf_cfg_if.sink     cfg
);

	rlf_pkg::cmd_t    cmd;
	rlf_pkg::status_t sts;
	rlf_pkg::item_t   item_pl;
	rlf_pkg::result_t res;
	logic             in_ready;
	logic             out_valid;

	assign item_pl.kind              = item.kind;
	assign item_pl.link_id           = item.link_id;
	assign item_pl.is_radio_status   = item.is_radio_status;
	assign item_pl.link_usb_direct   = item.link_usb_direct;
	assign item_pl.link_high_latency = item.link_high_latency;
	assign item.ready                = in_ready;
	assign cfg.ready                 = 1'b1;

	rlf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rlf_dp #(
		.LINKS    (LINKS),
		.AGE_BITS (AGE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.item      (item_pl),
		.cfg_valid (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.res       (res),
		.out_valid (out_valid),
		.out_ready (result.ready)
	);

	assign result.valid           = out_valid;
	assign result.primary_valid   = res.primary_valid;
	assign result.primary_link    = res.primary_link;
	assign result.primary_changed = res.primary_changed;
	assign result.lost_mask       = res.lost_mask;
	assign result.total_lost      = res.total_lost;
	assign result.hl_stop         = res.hl_stop;
	assign result.hl_stop_link    = res.hl_stop_link;
	assign result.hl_start        = res.hl_start;
	assign result.all_removed     = res.all_removed;
	assign result.link_count      = res.link_count;

`ifndef SYNTHESIS
	a_prim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.primary_valid |-> result.primary_link == '0)
		else $error("primary_link set without a primary");
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.hl_stop |-> result.hl_stop_link == '0)
		else $error("hl_stop_link set without hl_stop");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("item taken while the previous one is in work");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> 32'(result.link_count) <= LINKS)
		else $error("link count beyond table size");
`endif

endmodule
